/* hw/rtl/chm_pkg.sv */
// Shared types and constants of the chained hash map core.
// No dependencies; chm_rem, chm_regs, the top level and the testbench import this package.
package chm_pkg;

	localparam int DEF_MAX_BUCKETS  = 256;
	localparam int DEF_POOL_ENTRIES = 1024;

	localparam int CNT_W  = 9;
	localparam int DATA_W = 32;
	localparam int PADDR_W = 3;

	localparam logic [CNT_W-1:0]   BUCKET_COUNT_RESET = 9'd256;
	localparam logic [PADDR_W-1:0] ADDR_BUCKET_COUNT  = 3'd0;

	typedef enum logic [2:0] {
		CMD_GET           = 3'd0,
		CMD_SET           = 3'd1,
		CMD_INSERT        = 3'd2,
		CMD_INSERT_OR_SET = 3'd3,
		CMD_INSERT_OR_GET = 3'd4,
		CMD_ITER_FIRST    = 3'd5,
		CMD_ITER_NEXT     = 3'd6,
		CMD_NONE          = 3'd7
	} cmd_e;

	// Result of the remainder unit.
	typedef struct packed {
		logic             done;
		logic [CNT_W-1:0] rem;
	} rem_res_t;

endpackage

/* hw/rtl/chm_if.sv */
// Valid/ready channel interfaces of the chained hash map core.
// No dependencies.
interface chm_cmd_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [31:0] key;
	logic [31:0] value;

	modport source (output valid, cmd, key, value, input ready);
	modport sink   (input valid, cmd, key, value, output ready);
endinterface

interface chm_rsp_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic [31:0] value_out;
	logic [31:0] key_out;
	logic        table_full;

	modport source (output valid, ok, value_out, key_out, table_full, input ready);
	modport sink   (input valid, ok, value_out, key_out, table_full, output ready);
endinterface

/* hw/rtl/chm_rem.sv */
// Iterative remainder unit: 32-bit key modulo a 9-bit bucket count.
// Depends on chm_pkg; four restoring steps per cycle while busy.
module chm_rem import chm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	input  logic [CNT_W-1:0]  divisor,
	output rem_res_t          res
);

	localparam int STEPS = 4;

	logic [DATA_W-1:0] num_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  div_q;
	logic [2:0]        cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DATA_W-1:0] num_n;
	logic [CNT_W-1:0]  rem_n;

	always_comb begin
		logic [CNT_W:0] t;
		num_n = num_q;
		rem_n = rem_q;
		for (int i = 0; i < STEPS; i++) begin
			t = {rem_n, num_n[DATA_W-1]};
			num_n = {num_n[DATA_W-2:0], 1'b0};
			if (t >= {1'b0, div_q}) begin
				t = t - {1'b0, div_q};
			end
			rem_n = t[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && cnt_q == 3'd7;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			num_q <= num_n;
			rem_q <= rem_n;
		end
	end

	assign res.done = done_q;
	assign res.rem  = rem_q;

endmodule

/* hw/rtl/chm_regs.sv */
// APB-style configuration register file holding the bucket count.
// Depends on chm_pkg.
module chm_regs import chm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output logic [CNT_W-1:0]   bucket_count
);

	logic [CNT_W-1:0] bucket_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bucket_count_q <= BUCKET_COUNT_RESET;
		end else if (psel && penable && pwrite && paddr == ADDR_BUCKET_COUNT) begin
			bucket_count_q <= pwdata[CNT_W-1:0];
		end
	end

	assign prdata = (paddr == ADDR_BUCKET_COUNT) ? {{(32-CNT_W){1'b0}}, bucket_count_q} : 32'd0;
	assign pready = 1'b1;
	assign bucket_count = bucket_count_q;

endmodule

/* hw/rtl/chained_hash_map_core.sv */
// Top level of the chained hash map core: sequencer, bucket heads and node pool.
// Depends on chm_pkg, chm_if, chm_rem and chm_regs.
//
// The core is a key-value map with separate chaining. A command is taken as one
// transfer on req and answered by exactly one transfer on rsp. The bucket of a key
// is the key modulo the live bucket count, worked out by the remainder unit. The
// sequencer then reads the bucket head and walks the chain node by node, each node
// through a node memory read in ST_CHK and then a key compare in ST_CMP. A new node
// behind a nonempty chain is linked to the old tail in a further state, ST_LINK.
// Iteration reads the head of each empty bucket it skips in ST_SETTLE and ST_WHEAD
// and gives out the key and value of the node it finds in ST_WOUT. One command is
// in flight at a time; req.ready is high only between commands, while a finished
// result may still wait in the output register. After reset the core sweeps all
// MAX_BUCKETS bucket heads to empty, one head per cycle, and takes no command
// meanwhile; configuration writes are accepted at any time. When the pool of
// POOL_ENTRIES nodes is used up, insert commands that need a node report
// table_full and change nothing.
module chained_hash_map_core import chm_pkg::*; #(
	parameter int MAX_BUCKETS  = DEF_MAX_BUCKETS,
	parameter int POOL_ENTRIES = DEF_POOL_ENTRIES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	chm_cmd_if.sink            req,
	chm_rsp_if.source          rsp
);

	localparam int HW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
	localparam int IW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
	localparam int UW = $clog2(POOL_ENTRIES + 1);

	// A node reference; vld low means no node.
	typedef struct packed {
		logic          vld;
		logic [IW-1:0] idx;
	} link_t;

	localparam link_t NO_LINK = '{vld: 1'b0, idx: '0};

	typedef enum logic [13:0] {
		ST_CLEAR  = 14'b00000000000001,
		ST_IDLE   = 14'b00000000000010,
		ST_MOD    = 14'b00000000000100,
		ST_HEAD   = 14'b00000000001000,
		ST_CHK    = 14'b00000000010000,
		ST_CMP    = 14'b00000000100000,
		ST_HIT    = 14'b00000001000000,
		ST_MISS   = 14'b00000010000000,
		ST_LINK   = 14'b00000100000000,
		ST_WHEAD  = 14'b00001000000000,
		ST_WLINK  = 14'b00010000000000,
		ST_SETTLE = 14'b00100000000000,
		ST_WOUT   = 14'b01000000000000,
		ST_RESP   = 14'b10000000000000
	} state_t;

	state_t state_q;

	// Configuration.
	logic [CNT_W-1:0] bucket_count;
	logic [CNT_W-1:0] live;

	chm_regs u_regs (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.bucket_count (bucket_count)
	);

	// A count of zero acts as one, a count beyond the head store as its depth.
	always_comb begin
		if (bucket_count == '0) begin
			live = 9'd1;
		end else if ({23'd0, bucket_count} > MAX_BUCKETS) begin
			live = CNT_W'(MAX_BUCKETS);
		end else begin
			live = bucket_count;
		end
	end

	// Latched command and search state.
	logic [2:0]        cmd_q;
	logic [DATA_W-1:0] key_q;
	logic [DATA_W-1:0] val_q;
	logic [HW-1:0]     bkt_q;
	link_t             cur_q;
	link_t             last_q;
	logic [IW-1:0]     new_q;
	logic [UW-1:0]     used_q;
	logic [HW-1:0]     clr_q;

	// Iterator.
	logic [CNT_W-1:0]  walk_bkt_q;
	link_t             walk_ent_q;
	logic              walk_act_q;

	// Result being built, and the output register.
	logic              ok_q;
	logic [DATA_W-1:0] vout_q;
	logic [DATA_W-1:0] kout_q;
	logic              full_q;
	logic              out_vld_q;
	logic              out_ok_q;
	logic [DATA_W-1:0] out_vout_q;
	logic [DATA_W-1:0] out_kout_q;
	logic              out_full_q;

	logic              accept;
	logic              is_ins;
	logic              pool_full;
	logic              out_free;
	logic [CNT_W:0]    walk_nxt;

	assign accept    = req.valid && req.ready;
	assign is_ins    = cmd_q == CMD_INSERT || cmd_q == CMD_INSERT_OR_SET ||
	                   cmd_q == CMD_INSERT_OR_GET;
	assign pool_full = used_q >= UW'(POOL_ENTRIES);
	assign out_free  = !out_vld_q || rsp.ready;
	assign walk_nxt  = {1'b0, walk_bkt_q} + 10'd1;

	// Remainder unit.
	rem_res_t rem_res;
	logic     rem_start;

	assign rem_start = accept && req.cmd <= CMD_INSERT_OR_GET;

	chm_rem u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rem_start),
		.dividend (req.key),
		.divisor  (live),
		.res      (rem_res)
	);

	// Bucket head memory.
	link_t         head_mem [MAX_BUCKETS];
	link_t         head_rd_q;
	logic          head_we;
	logic [HW-1:0] head_waddr;
	link_t         head_wdata;
	logic [HW-1:0] head_raddr;

	// Node pool memories.
	logic [DATA_W-1:0] key_mem  [POOL_ENTRIES];
	logic [DATA_W-1:0] val_mem  [POOL_ENTRIES];
	link_t             link_mem [POOL_ENTRIES];
	logic [DATA_W-1:0] key_rd_q;
	logic [DATA_W-1:0] val_rd_q;
	link_t             link_rd_q;
	logic [IW-1:0]     node_raddr;
	logic              key_we;
	logic              val_we;
	logic [IW-1:0]     val_waddr;
	logic [DATA_W-1:0] val_wdata;
	logic              link_we;
	logic [IW-1:0]     link_waddr;
	link_t             link_wdata;

	always_comb begin
		head_we    = 1'b0;
		head_waddr = bkt_q;
		head_wdata = '{vld: 1'b1, idx: used_q[IW-1:0]};
		head_raddr = '0;
		node_raddr = walk_ent_q.idx;
		key_we     = 1'b0;
		val_we     = 1'b0;
		val_waddr  = used_q[IW-1:0];
		val_wdata  = val_q;
		link_we    = 1'b0;
		link_waddr = used_q[IW-1:0];
		link_wdata = NO_LINK;
		unique case (state_q)
			ST_CLEAR: begin
				head_we    = 1'b1;
				head_waddr = clr_q;
				head_wdata = NO_LINK;
			end
			ST_MOD: begin
				head_raddr = HW'(rem_res.rem);
			end
			ST_CHK, ST_CMP: begin
				// The node under test stays addressed so that its value is
				// available on a match.
				node_raddr = cur_q.idx;
			end
			ST_HIT: begin
				// Set and insert-or-set overwrite the value of the node found.
				val_we    = cmd_q == CMD_SET || cmd_q == CMD_INSERT_OR_SET;
				val_waddr = cur_q.idx;
			end
			ST_MISS: begin
				// A new node goes at the next free pool slot; an empty chain gets
				// it as its head right away, otherwise the tail is linked next.
				key_we  = is_ins && !pool_full;
				val_we  = is_ins && !pool_full;
				link_we = is_ins && !pool_full;
				head_we = is_ins && !pool_full && !last_q.vld;
			end
			ST_LINK: begin
				link_we    = 1'b1;
				link_waddr = last_q.idx;
				link_wdata = '{vld: 1'b1, idx: new_q};
			end
			ST_SETTLE: begin
				head_raddr = HW'(walk_nxt);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (head_we) begin
			head_mem[head_waddr] <= head_wdata;
		end
		head_rd_q <= head_mem[head_raddr];
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[used_q[IW-1:0]] <= key_q;
		end
		if (val_we) begin
			val_mem[val_waddr] <= val_wdata;
		end
		if (link_we) begin
			link_mem[link_waddr] <= link_wdata;
		end
		key_rd_q  <= key_mem[node_raddr];
		val_rd_q  <= val_mem[node_raddr];
		link_rd_q <= link_mem[node_raddr];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			used_q     <= '0;
			walk_bkt_q <= '0;
			walk_ent_q <= NO_LINK;
			walk_act_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (state_q == ST_RESP && out_free) begin
				out_vld_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + HW'(1);
					if (clr_q == HW'(MAX_BUCKETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						ok_q   <= 1'b0;
						vout_q <= '0;
						kout_q <= '0;
						full_q <= 1'b0;
						priority if (req.cmd <= CMD_INSERT_OR_GET) begin
							state_q <= ST_MOD;
						end else if (req.cmd == CMD_ITER_FIRST ||
						             (req.cmd == CMD_ITER_NEXT && !walk_act_q)) begin
							// Head of bucket zero is being read this cycle.
							walk_act_q <= 1'b1;
							walk_bkt_q <= '0;
							state_q    <= ST_WHEAD;
						end else if (req.cmd == CMD_ITER_NEXT) begin
							state_q <= walk_ent_q.vld ? ST_WLINK : ST_SETTLE;
						end else begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_MOD: begin
					if (rem_res.done) begin
						bkt_q   <= HW'(rem_res.rem);
						state_q <= ST_HEAD;
					end
				end
				ST_HEAD: begin
					cur_q   <= head_rd_q;
					last_q  <= NO_LINK;
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					state_q <= cur_q.vld ? ST_CMP : ST_MISS;
				end
				ST_CMP: begin
					if (key_rd_q == key_q) begin
						state_q <= ST_HIT;
					end else begin
						last_q  <= cur_q;
						cur_q   <= link_rd_q;
						state_q <= ST_CHK;
					end
				end
				ST_HIT: begin
					ok_q    <= cmd_q == CMD_GET || cmd_q == CMD_SET ||
					           cmd_q == CMD_INSERT_OR_GET;
					if (cmd_q == CMD_GET || cmd_q == CMD_INSERT_OR_GET) begin
						vout_q <= val_rd_q;
					end
					state_q <= ST_RESP;
				end
				ST_MISS: begin
					state_q <= (is_ins && !pool_full && last_q.vld) ? ST_LINK : ST_RESP;
					if (is_ins) begin
						if (pool_full) begin
							full_q <= 1'b1;
						end else begin
							used_q <= used_q + UW'(1);
							new_q  <= used_q[IW-1:0];
							ok_q   <= cmd_q != CMD_INSERT_OR_GET;
						end
					end
				end
				ST_LINK: begin
					state_q <= ST_RESP;
				end
				ST_WHEAD: begin
					walk_ent_q <= head_rd_q;
					state_q    <= ST_SETTLE;
				end
				ST_WLINK: begin
					walk_ent_q <= link_rd_q;
					state_q    <= ST_SETTLE;
				end
				ST_SETTLE: begin
					// Skip empty buckets; past the last live one the walk stays ended.
					priority if (walk_ent_q.vld) begin
						state_q <= ST_WOUT;
					end else if (walk_nxt >= {1'b0, live}) begin
						walk_bkt_q <= live;
						walk_ent_q <= NO_LINK;
						state_q    <= ST_RESP;
					end else begin
						walk_bkt_q <= walk_nxt[CNT_W-1:0];
						state_q    <= ST_WHEAD;
					end
				end
				ST_WOUT: begin
					ok_q    <= 1'b1;
					kout_q  <= key_rd_q;
					vout_q  <= val_rd_q;
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command latch and output payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= req.cmd;
			key_q  <= req.key;
			val_q  <= req.value;
		end
		if (state_q == ST_RESP && out_free) begin
			out_ok_q   <= ok_q;
			out_vout_q <= vout_q;
			out_kout_q <= kout_q;
			out_full_q <= full_q;
		end
	end

	assign req.ready      = state_q == ST_IDLE;
	assign rsp.valid      = out_vld_q;
	assign rsp.ok         = out_ok_q;
	assign rsp.value_out  = out_vout_q;
	assign rsp.key_out    = out_kout_q;
	assign rsp.table_full = out_full_q;

endmodule

/* hw/rtl/chm_checker.sv */
// Port-level assertions for the chained hash map core, bound to the top level.
// Depends on chained_hash_map_core.
module chm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        rsp_ok,
	input logic        rsp_full,
	input logic [31:0] rsp_value_out,
	input logic [31:0] rsp_key_out
);

	logic [1:0] pend_q;
	logic       in_x;
	logic       out_x;

	assign in_x  = req_valid && req_ready;
	assign out_x = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, in_x} - {1'b0, out_x};
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped before transfer");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_x |=> !req_ready)
		else $error("command taken while another is in flight");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("response without a command");

	a_full_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_full |-> !rsp_ok)
		else $error("table full reported with success");

	a_zero_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ok |-> rsp_value_out == 32'd0 && rsp_key_out == 32'd0)
		else $error("nonzero payload on a failed command");

endmodule

bind chained_hash_map_core chm_checker u_chm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_ok        (rsp.ok),
	.rsp_full      (rsp.table_full),
	.rsp_value_out (rsp.value_out),
	.rsp_key_out   (rsp.key_out)
);

/* sim/tb.sv */
// Self-checking testbench of chained_hash_map_core: random and directed map commands.
// Depends on chm_pkg, chm_if and the core RTL; it reads no file and needs no arguments.
module tb;
	import chm_pkg::*;

	localparam int POOL = DEF_POOL_ENTRIES;
	localparam int HEADS = DEF_MAX_BUCKETS;
	localparam logic [10:0] NIL = 11'h7FF;

	typedef struct {
		cmd_e        cmd;
		logic [31:0] key;
		logic [31:0] value;
	} map_cmd_t;

	typedef struct {
		logic        ok;
		logic [31:0] value_out;
		logic [31:0] key_out;
		logic        table_full;
	} map_rsp_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	chm_cmd_if req_if();
	chm_rsp_if rsp_if();

	chained_hash_map_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req_if),
		.rsp     (rsp_if)
	);

	// Shadow of the map: bucket heads, node pool, pool fill level and the walk cursor.
	logic [10:0] head_of[HEADS];
	logic [31:0] node_key[POOL];
	logic [31:0] node_val[POOL];
	logic [10:0] node_next[POOL];
	int          nodes_used;
	int          walk_bkt;
	logic [10:0] walk_node;
	logic        walk_on;
	logic [8:0]  bucket_cnt;

	map_cmd_t    cmd_queue[$];
	map_rsp_t    rsp_expected[$];
	logic [31:0] known_keys[$];

	int errors;
	int cmd_gap;
	int rsp_wait;
	int rsp_seen;
	bit no_idle;

	// Applies one command to the shadow map and returns the response it must produce.
	function automatic map_rsp_t apply_map_cmd(map_cmd_t c);
		map_rsp_t    r;
		int          live;
		int          b;
		logic [10:0] cur;
		logic [10:0] last;
		logic        found;
		logic        settled;
		r = '{default: '0};
		live = (bucket_cnt == 0) ? 1 : ((bucket_cnt > HEADS) ? HEADS : int'(bucket_cnt));
		b = c.key % live;
		cur = head_of[b];
		last = NIL;
		found = 1'b0;
		while (cur < POOL && !found) begin
			if (node_key[cur] == c.key) begin
				found = 1'b1;
			end else begin
				last = cur;
				cur = node_next[cur];
			end
		end
		case (c.cmd)
			CMD_GET: begin
				if (found) begin
					r.ok = 1'b1;
					r.value_out = node_val[cur];
				end
			end
			CMD_SET: begin
				if (found) begin
					r.ok = 1'b1;
					node_val[cur] = c.value;
				end
			end
			CMD_INSERT, CMD_INSERT_OR_SET, CMD_INSERT_OR_GET: begin
				if (found) begin
					if (c.cmd == CMD_INSERT_OR_SET) node_val[cur] = c.value;
					if (c.cmd == CMD_INSERT_OR_GET) begin
						r.ok = 1'b1;
						r.value_out = node_val[cur];
					end
				end else if (nodes_used >= POOL) begin
					r.table_full = 1'b1;
				end else begin
					node_key[nodes_used] = c.key;
					node_val[nodes_used] = c.value;
					node_next[nodes_used] = NIL;
					if (last < POOL) node_next[last] = 11'(nodes_used);
					else head_of[b] = 11'(nodes_used);
					nodes_used++;
					if (c.cmd != CMD_INSERT_OR_GET) r.ok = 1'b1;
				end
			end
			CMD_ITER_FIRST, CMD_ITER_NEXT: begin
				if (c.cmd == CMD_ITER_FIRST || !walk_on) begin
					walk_on = 1'b1;
					walk_bkt = 0;
					walk_node = head_of[0];
				end else if (walk_node < POOL) begin
					walk_node = node_next[walk_node];
				end
				// Skip empty buckets; running off the last one parks the walk at the end.
				settled = 1'b0;
				while (walk_node >= POOL && !settled) begin
					if (walk_bkt + 1 >= live) begin
						walk_bkt = live;
						walk_node = NIL;
						settled = 1'b1;
					end else begin
						walk_bkt++;
						walk_node = head_of[walk_bkt];
					end
				end
				if (walk_node < POOL) begin
					r.ok = 1'b1;
					r.key_out = node_key[walk_node];
					r.value_out = node_val[walk_node];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// Half the picks reuse a key of an earlier insert, so that chains are searched to a match.
	function automatic logic [31:0] pick_key();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 5 && known_keys.size() > 0)
			return known_keys[$urandom_range(0, known_keys.size() - 1)];
		if (sel == 7) return 32'($urandom_range(0, 15));
		if (sel == 8) return ~32'($urandom_range(0, 15));
		return $urandom;
	endfunction

	function automatic map_cmd_t random_cmd();
		map_cmd_t c;
		int       w;
		c.key = pick_key();
		c.value = $urandom;
		w = $urandom_range(0, 99);
		if (w < 8) begin
			c.cmd = cmd_e'($urandom_range(0, 7));
			c.key = $urandom;
		end else if (w < 28) c.cmd = CMD_GET;
		else if (w < 38) c.cmd = CMD_SET;
		else if (w < 58) c.cmd = CMD_INSERT;
		else if (w < 70) c.cmd = CMD_INSERT_OR_SET;
		else if (w < 82) c.cmd = CMD_INSERT_OR_GET;
		else if (w < 86) c.cmd = CMD_ITER_FIRST;
		else c.cmd = CMD_ITER_NEXT;
		if (c.cmd inside {CMD_INSERT, CMD_INSERT_OR_SET, CMD_INSERT_OR_GET})
			known_keys.push_back(c.key);
		return c;
	endfunction

	task automatic queue_cmd(cmd_e c, logic [31:0] k, logic [31:0] v);
		cmd_queue.push_back('{cmd: c, key: k, value: v});
		if (c inside {CMD_INSERT, CMD_INSERT_OR_SET, CMD_INSERT_OR_GET}) known_keys.push_back(k);
	endtask

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++) cmd_queue.push_back(random_cmd());
	endtask

	// Waits until every queued command was taken and answered, then lets the core settle.
	task automatic drain();
		do @(posedge clk);
		while (cmd_queue.size() != 0 || req_if.valid || rsp_expected.size() != 0);
		repeat (20) @(posedge clk);
	endtask

	// One APB write: setup cycle, then access cycle; pready is always high.
	task automatic write_bucket_count(logic [8:0] v);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_BUCKET_COUNT;
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		bucket_cnt = v;
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Command driver. A command is predicted at the edge where its transfer happens,
	// so the shadow map sees commands in exactly the order the core takes them.
	always @(posedge clk) begin
		logic     next_valid;
		map_cmd_t c;
		if (arst_n) begin
			next_valid = req_if.valid;
			if (req_if.valid && req_if.ready) begin
				c.cmd = cmd_e'(req_if.cmd);
				c.key = req_if.key;
				c.value = req_if.value;
				rsp_expected.push_back(apply_map_cmd(c));
				next_valid = 1'b0;
				cmd_gap = no_idle ? 0 : $urandom_range(0, 13);
			end
			if (!next_valid) begin
				if (cmd_gap > 0) begin
					cmd_gap--;
				end else if (cmd_queue.size() != 0) begin
					c = cmd_queue.pop_front();
					req_if.cmd <= c.cmd;
					req_if.key <= c.key;
					req_if.value <= c.value;
					next_valid = 1'b1;
				end
			end
			req_if.valid <= next_valid;
		end
	end

	// Response monitor. Each transfer is checked against the oldest expected response;
	// afterwards, unless no_idle is set, the receiver stalls a random number of cycles. Once, it holds off long
	// enough for the core to fill its output register and stop taking commands.
	always @(posedge clk) begin
		map_rsp_t e;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				if (rsp_expected.size() == 0) begin
					$display("%0t: response with none expected: ok=%0b value_out=%h key_out=%h full=%0b",
						$time, rsp_if.ok, rsp_if.value_out, rsp_if.key_out, rsp_if.table_full);
					errors++;
				end else begin
					e = rsp_expected.pop_front();
					if (rsp_if.ok !== e.ok) begin
						$display("%0t: ok expected %0b actual %0b", $time, e.ok, rsp_if.ok);
						errors++;
					end
					if (rsp_if.value_out !== e.value_out) begin
						$display("%0t: value_out expected %h actual %h", $time, e.value_out,
							rsp_if.value_out);
						errors++;
					end
					if (rsp_if.key_out !== e.key_out) begin
						$display("%0t: key_out expected %h actual %h", $time, e.key_out,
							rsp_if.key_out);
						errors++;
					end
					if (rsp_if.table_full !== e.table_full) begin
						$display("%0t: table_full expected %0b actual %0b", $time, e.table_full,
							rsp_if.table_full);
						errors++;
					end
				end
				rsp_seen++;
				rsp_wait = no_idle ? 0 : $urandom_range(0, 13);
				if (rsp_seen == 400) rsp_wait = 600;
			end else if (rsp_wait > 0) begin
				rsp_wait--;
			end
			rsp_if.ready <= (rsp_wait == 0);
		end
	end

	initial begin
		#(12 * 10000000);
		$display("chained_hash_map_core regression: fail");
		$finish;
	end

	initial begin
		errors = 0;
		cmd_gap = 0;
		rsp_wait = 0;
		rsp_seen = 0;
		no_idle = 1'b0;
		nodes_used = 0;
		walk_bkt = 0;
		walk_node = NIL;
		walk_on = 1'b0;
		bucket_cnt = BUCKET_COUNT_RESET;
		for (int i = 0; i < HEADS; i++) head_of[i] = NIL;
		for (int i = 0; i < POOL; i++) node_next[i] = NIL;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_if.valid = 1'b0;
		req_if.cmd = CMD_NONE;
		req_if.key = '0;
		req_if.value = '0;
		rsp_if.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part with a single bucket, so every key shares one chain.
		write_bucket_count(9'd1);
		queue_cmd(CMD_ITER_NEXT, 32'h0, 32'h0);            // walk never started, map empty
		queue_cmd(CMD_GET, 32'h0, 32'h0);
		queue_cmd(CMD_SET, 32'hFFFF_FFFF, 32'h1);
		queue_cmd(CMD_INSERT, 32'h0, 32'hFFFF_FFFF);
		queue_cmd(CMD_INSERT, 32'hFFFF_FFFF, 32'h0);
		queue_cmd(CMD_INSERT, 32'h0, 32'h1234_5678);        // duplicate key
		queue_cmd(CMD_INSERT_OR_SET, 32'h0, 32'h5A5A_5A5A); // overwrites
		queue_cmd(CMD_INSERT_OR_SET, 32'h1234_5678, 32'hA5A5_A5A5);
		queue_cmd(CMD_INSERT_OR_GET, 32'h0, 32'h0);
		queue_cmd(CMD_INSERT_OR_GET, 32'h8000_0000, 32'h1);
		queue_cmd(CMD_GET, 32'h0, 32'h0);
		queue_cmd(CMD_GET, 32'hFFFF_FFFF, 32'h0);
		queue_cmd(CMD_GET, 32'h7FFF_FFFF, 32'h0);
		queue_cmd(CMD_SET, 32'hFFFF_FFFF, 32'h3333_3333);
		queue_cmd(CMD_ITER_FIRST, 32'h0, 32'h0);
		queue_cmd(CMD_ITER_NEXT, 32'h0, 32'h0);
		queue_cmd(CMD_INSERT, 32'h0000_00FF, 32'hCAFE_0001); // lands behind the cursor
		queue_cmd(CMD_ITER_NEXT, 32'h0, 32'h0);
		queue_cmd(CMD_ITER_NEXT, 32'h0, 32'h0);
		queue_cmd(CMD_ITER_NEXT, 32'h0, 32'h0);
		queue_cmd(CMD_ITER_NEXT, 32'h0, 32'h0);              // past the end
		queue_cmd(CMD_ITER_NEXT, 32'h0, 32'h0);              // stays ended
		queue_cmd(CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drain();

		// A count of zero behaves as one bucket.
		write_bucket_count(9'd0);
		queue_random(30);
		drain();

		// Counts above the bucket array clamp to its size.
		write_bucket_count(9'd511);
		queue_random(30);
		drain();

		// Main random run at full size; the first stretch has no idling on either side.
		write_bucket_count(9'd256);
		no_idle = 1'b1;
		queue_random(60);
		drain();
		no_idle = 1'b0;
		queue_random(140);
		drain();

		// Few buckets over a well-filled pool give long chains.
		write_bucket_count(9'd7);
		queue_random(100);
		drain();

		// Use up the pool, then keep inserting to see the full flag.
		write_bucket_count(9'd256);
		for (int i = nodes_used; i < POOL + 15; i++)
			queue_cmd(cmd_e'($urandom_range(CMD_INSERT, CMD_INSERT_OR_GET)), $urandom, $urandom);
		queue_random(60);
		drain();

		repeat (50) @(posedge clk);
		if (errors == 0 && rsp_expected.size() == 0) begin
			$display("chained_hash_map_core regression: pass");
		end else begin
			if (rsp_expected.size() != 0)
				$display("%0t: %0d expected responses never arrived", $time, rsp_expected.size());
			$display("chained_hash_map_core regression: fail");
		end
		$finish;
	end

endmodule
